@@ hdl/scrolling_led_matrix_row_composer_defines.svh @@
// Assertion macros for the row composer, which checks itself.
`ifndef SCROLLING_LED_MATRIX_ROW_COMPOSER_DEFINES_SVH
`define SCROLLING_LED_MATRIX_ROW_COMPOSER_DEFINES_SVH

// Checked at every rising clock edge outside reset.
`define SLMR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define SLMR_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ hdl/slmr_pkg.sv @@
package slmr_pkg;

   // Glyph store geometry.
   localparam int GLYPH_SLOTS = 32;
   localparam int GLYPH_BYTES = 32;
   localparam int SLOT_W      = $clog2(GLYPH_SLOTS);
   localparam int COUNT_W     = SLOT_W + 1;
   localparam int POS_W       = $clog2(GLYPH_BYTES);
   localparam int ADDR_W      = SLOT_W + POS_W;
   localparam int STORE_DEPTH = GLYPH_SLOTS * GLYPH_BYTES;

   // Field widths.
   localparam int BYTE_W   = 8;
   localparam int ROW_W    = 4;
   localparam int PIX_W    = 64;
   localparam int PERIOD_W = 16;
   localparam int OFFS_W   = 4;
   localparam int FINE_W   = 3;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(30);
   localparam logic [BYTE_W-1:0]   START_FIRST  = 8'h55;
   localparam logic [BYTE_W-1:0]   START_SECOND = 8'hAA;

   // One row needs nine consecutive bytes out of the ten of five glyphs.
   localparam int READ_BYTES = 9;
   localparam int RD_CNT_W   = 4;
   localparam logic [RD_CNT_W-1:0] RD_LAST = RD_CNT_W'(READ_BYTES - 1);

   // Beat kinds carried in the request tuser bit.
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [BYTE_W-1:0] data;
   } wr_req_type;

   typedef struct packed {
      logic              valid;
      logic              first;
      logic              last;
      logic              live;
      logic [ADDR_W-1:0] addr;
   } rd_req_type;

   typedef struct packed {
      logic              valid;
      logic              first;
      logic              last;
      logic [BYTE_W-1:0] data;
   } rd_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_WAIT = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

endpackage

@@ hdl/slmr_glyph_store.sv @@
module slmr_glyph_store import slmr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  wr_req_type wr,
   input  rd_req_type rd,
   output rd_rsp_type rsp
);

   logic [BYTE_W-1:0] mem [STORE_DEPTH];
   logic [BYTE_W-1:0] rdata_ff;
   logic              live_ff;
   logic              valid_ff;
   logic              first_ff;
   logic              last_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.valid) begin
         rdata_ff <= mem[rd.addr];
      end
   end

   always_ff @(posedge clock) begin
      live_ff  <= rd.live;
      first_ff <= rd.first;
      last_ff  <= rd.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= rd.valid;
      end
   end

   // Entries beyond the fill point read as cleared.
   always_comb begin
      rsp.valid = valid_ff;
      rsp.first = first_ff;
      rsp.last  = last_ff;
      rsp.data  = live_ff ? rdata_ff : '0;
   end

endmodule

@@ hdl/slmr_row_shifter.sv @@
module slmr_row_shifter import slmr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  rd_rsp_type        rsp,
   input  logic [FINE_W-1:0] fine_shift,
   output logic [PIX_W-1:0]  row_pixels,
   output logic              row_done
);

   logic [BYTE_W-1:0]   prev_ff;
   logic [PIX_W-1:0]    pix_ff;
   logic                done_ff;
   logic [2*BYTE_W-1:0] pair;
   logic [2*BYTE_W-1:0] pair_shifted;

   // Each output byte is a window of two neighbouring glyph bytes.
   always_comb begin
      pair         = {rsp.data, prev_ff};
      pair_shifted = pair >> fine_shift;
   end

   always_ff @(posedge clock) begin
      if (rsp.valid) begin
         prev_ff <= rsp.data;
         if (!rsp.first) begin
            pix_ff <= {pair_shifted[BYTE_W-1:0], pix_ff[PIX_W-1:BYTE_W]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= rsp.valid && rsp.last;
      end
   end

   assign row_pixels = pix_ff;
   assign row_done   = done_ff;

endmodule

@@ hdl/scrolling_led_matrix_row_composer.sv @@
// Channel  Direction  Beat fields (tdata / tuser)
// req      in         tdata: byte_value[7:0]; tuser: cmd (0 byte, 1 scan tick)
// rsp      out        tdata: row_index[3:0], row_pixels[67:4], zero pad [71:68]
// csr      in         csr_wdata: scroll_period, written when csr_wen is high
//
// A received byte, or a scan tick while scrolling is stopped, is taken without leaving idle.
// A scan tick while running starts a read pass: nine bytes are read one per cycle from the
// glyph store and funneled into the row one byte at a time.
// Reset is synchronous; the glyph store needs no clearing pass because a fill pointer
// marks which entries hold data since the last clear, so the block is ready at once.
// A result waits in the output register; byte beats are still taken meanwhile, and a
// finished row stalls only while the previous one has not been taken.
`include "scrolling_led_matrix_row_composer_defines.svh"

module scrolling_led_matrix_row_composer import slmr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,   // byte_value[7:0]
   input  logic [0:0]    req_tuser,   // cmd[0]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [71:0]   rsp_tdata,   // row_index[3:0], row_pixels[67:4], zero [71:68]
   input  logic          csr_wen,
   input  logic [15:0]   csr_wdata
);

   state_type state_ff, state_in;

   logic [PERIOD_W-1:0] scroll_period_ff;
   logic [BYTE_W-1:0]   previous_byte_ff, previous_byte_in;
   logic                running_ff, running_in;
   // The slot pointer saturates exactly like the glyph count, so it serves as both.
   logic [COUNT_W-1:0]  write_slot_ff, write_slot_in;
   logic [POS_W-1:0]    write_offset_ff, write_offset_in;
   logic [PERIOD_W-1:0] speed_count_ff, speed_count_in;
   logic [OFFS_W-1:0]   bit_offset_ff, bit_offset_in;
   logic [SLOT_W-1:0]   first_glyph_ff, first_glyph_in;
   logic [ROW_W-1:0]    scan_row_ff, scan_row_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [RD_CNT_W-1:0] rd_cnt_ff, rd_cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]    rsp_row_ff;
   logic [PIX_W-1:0]    rsp_pix_ff;

   logic                req_accept;
   logic                byte_beat;
   logic                tick_beat;
   logic [BYTE_W-1:0]   rx_byte;
   logic                stop_pair;
   logic [COUNT_W-1:0]  slot_eff;
   logic [POS_W-1:0]    offset_eff;
   logic [PERIOD_W-1:0] speed_next;
   logic [COUNT_W-1:0]  glyph_next;
   logic [RD_CNT_W-1:0] byte_idx;
   logic [COUNT_W-1:0]  rd_glyph;
   logic [POS_W-1:0]    rd_pos;
   logic                out_free;

   wr_req_type          wr;
   rd_req_type          rd;
   rd_rsp_type          rd_rsp;
   logic [PIX_W-1:0]    row_pixels;
   logic                row_done;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign byte_beat  = req_accept && (req_tuser[0] == CMD_BYTE);
   assign tick_beat  = req_accept && (req_tuser[0] == CMD_TICK);
   assign rx_byte    = req_tdata;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // The stop pair rewinds the write position before its second byte is stored.
   assign stop_pair  = (previous_byte_ff == START_SECOND) && (rx_byte == START_FIRST);
   assign slot_eff   = stop_pair ? '0 : write_slot_ff;
   assign offset_eff = stop_pair ? '0 : write_offset_ff;

   always_comb begin
      wr.en   = byte_beat && (slot_eff < COUNT_W'(GLYPH_SLOTS));
      wr.addr = {slot_eff[SLOT_W-1:0], offset_eff};
      wr.data = rx_byte;
   end

   assign speed_next = speed_count_ff + PERIOD_W'(1);
   assign glyph_next = {1'b0, first_glyph_ff} + COUNT_W'(1);

   always_comb begin
      previous_byte_in = previous_byte_ff;
      running_in       = running_ff;
      write_slot_in    = write_slot_ff;
      write_offset_in  = write_offset_ff;
      speed_count_in   = speed_count_ff;
      bit_offset_in    = bit_offset_ff;
      first_glyph_in   = first_glyph_ff;
      scan_row_in      = scan_row_ff;
      row_in           = row_ff;
      if (byte_beat) begin
         previous_byte_in = rx_byte;
         if ((previous_byte_ff == START_FIRST) && (rx_byte == START_SECOND)) begin
            running_in = 1'b1;
         end
         if (stop_pair) begin
            running_in = 1'b0;
         end
         write_offset_in = offset_eff + POS_W'(1);
         write_slot_in   = slot_eff;
         // A slot is complete when the offset wraps; the pointer stops at capacity.
         if ((offset_eff == '1) && (slot_eff < COUNT_W'(GLYPH_SLOTS))) begin
            write_slot_in = slot_eff + COUNT_W'(1);
         end
      end
      if (tick_beat && running_ff) begin
         speed_count_in = speed_next;
         if (speed_next >= scroll_period_ff) begin
            speed_count_in = '0;
            bit_offset_in  = bit_offset_ff + OFFS_W'(1);
            // Passing the last bit of a glyph moves the window one glyph on, or back to glyph zero past the fill.
            if (bit_offset_ff == '1) begin
               first_glyph_in = glyph_next[SLOT_W-1:0];
               if (glyph_next >= write_slot_ff) begin
                  first_glyph_in = '0;
               end
            end
         end
         row_in      = scan_row_ff;
         scan_row_in = scan_row_ff + ROW_W'(1);
      end
   end

   // Sequencer: issue nine reads, wait for the funnel, then hand the row over.
   always_comb begin
      state_in     = state_ff;
      rd_cnt_in    = rd_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            rd_cnt_in = '0;
            if (tick_beat && running_ff) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            rd_cnt_in = rd_cnt_ff + RD_CNT_W'(1);
            if (rd_cnt_ff == RD_LAST) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (row_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Byte idx walks nine of the ten glyph bytes of the row; the upper half offset skips the first.
   assign byte_idx = rd_cnt_ff + RD_CNT_W'(bit_offset_ff[OFFS_W-1]);
   assign rd_glyph = {1'b0, first_glyph_ff} + COUNT_W'(byte_idx[RD_CNT_W-1:1]);
   assign rd_pos   = {row_ff, byte_idx[0]};

   always_comb begin
      rd.valid = (state_ff == ST_READ);
      rd.first = (rd_cnt_ff == '0);
      rd.last  = (rd_cnt_ff == RD_LAST);
      // Live only inside capacity and below the fill point since the last clear.
      rd.live  = (rd_glyph < COUNT_W'(GLYPH_SLOTS))
               && ({rd_glyph, rd_pos} < {write_slot_ff, write_offset_ff});
      rd.addr  = {rd_glyph[SLOT_W-1:0], rd_pos};
   end

   slmr_glyph_store u_store (
      .clock (clock),
      .reset (reset),
      .wr    (wr),
      .rd    (rd),
      .rsp   (rd_rsp)
   );

   slmr_row_shifter u_shifter (
      .clock      (clock),
      .reset      (reset),
      .rsp        (rd_rsp),
      .fine_shift (bit_offset_ff[FINE_W-1:0]),
      .row_pixels (row_pixels),
      .row_done   (row_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         scroll_period_ff <= PERIOD_RESET;
         previous_byte_ff <= '0;
         running_ff       <= 1'b0;
         write_slot_ff    <= '0;
         write_offset_ff  <= '0;
         speed_count_ff   <= '0;
         bit_offset_ff    <= '0;
         first_glyph_ff   <= '0;
         scan_row_ff      <= '0;
         row_ff           <= '0;
         rd_cnt_ff        <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         if (csr_wen) begin
            scroll_period_ff <= csr_wdata;
         end
         previous_byte_ff <= previous_byte_in;
         running_ff       <= running_in;
         write_slot_ff    <= write_slot_in;
         write_offset_ff  <= write_offset_in;
         speed_count_ff   <= speed_count_in;
         bit_offset_ff    <= bit_offset_in;
         first_glyph_ff   <= first_glyph_in;
         scan_row_ff      <= scan_row_in;
         row_ff           <= row_in;
         rd_cnt_ff        <= rd_cnt_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_OUT) && out_free) begin
         rsp_row_ff <= row_ff;
         rsp_pix_ff <= row_pixels;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_pix_ff, rsp_row_ff};

   `SLMR_ASSERT(a_tick_read, tick_beat && running_ff |=> state_ff == ST_READ, "read not started")
   `SLMR_ASSERT(a_done_in_wait, row_done |-> state_ff == ST_WAIT, "row done outside wait")
   `SLMR_ASSERT(a_slot_capacity, write_slot_ff <= COUNT_W'(GLYPH_SLOTS), "slot past capacity")
   `SLMR_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_tvalid && req_tready, "busy after reset")

endmodule

@@ verif/tb_scrolling_led_matrix_row_composer.sv @@
`timescale 1ns / 100ps

// The testbench streams received bytes and scan ticks into the row composer and
// checks every row word that comes back against its own model of the glyph store,
// the scroll counters and the scan row. The model is advanced at the clock edge at
// which a request beat is accepted, so its view always matches what the block has
// actually taken in. The sender works in random bursts, and the receiver stalls on
// patterns of its own, with two long hold-offs that back the block up.
module tb_scrolling_led_matrix_row_composer;
   import slmr_pkg::*;

   // This pause covers any work the block may still have in flight.
   localparam int SETTLE_CYCLES   = 24;
   // Longest legal quiet stretch is a long hold-off plus a sender gap; keep a wide margin.
   localparam int QUIET_LIMIT     = 5000;
   localparam int LONG_HOLD_LEN   = 600;
   localparam int FIRST_HOLD_ROW  = 30;
   localparam int SECOND_HOLD_ROW = 400;
   // Enough bytes in the deep fill to pass the store capacity.
   localparam int DEEP_FILL_BYTES = 1030;
   // Enough running ticks for the first glyph to walk past slot 27.
   localparam int DEEP_TICKS      = 460;
   localparam int RANDOM_TARGET   = 150;

   typedef struct packed {
      logic              cmd;
      logic [BYTE_W-1:0] value;
   } req_beat_type;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [PIX_W-1:0] pixels;
   } row_word_type;

   typedef enum int {
      RDY_FREE,
      RDY_COIN,
      RDY_SPARSE,
      RDY_EVERY_THIRD
   } ready_mode_type;

   typedef enum int {
      NOISE_TICK,
      NOISE_RAW_BYTE,
      NOISE_HALF_START,
      NOISE_HALF_STOP,
      NOISE_LONE_FIRST,
      NOISE_LONE_SECOND
   } noise_kind_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [7:0]    req_tdata = '0;    // byte_value[7:0]
   logic [0:0]    req_tuser = '0;    // cmd[0]
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [71:0]   rsp_tdata;         // row_index[3:0], row_pixels[67:4], zero [71:68]
   logic          csr_wen = 1'b0;
   logic [15:0]   csr_wdata = '0;

   scrolling_led_matrix_row_composer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Row model: glyph store, write position, scroll counters, scan row.
   // ------------------------------------------------------------------
   logic [BYTE_W-1:0]   glyph_mem [STORE_DEPTH];
   logic [BYTE_W-1:0]   last_byte   = '0;
   logic                scrolling   = 1'b0;
   logic [COUNT_W-1:0]  slot_ptr    = '0;
   logic [POS_W-1:0]    byte_ptr    = '0;
   logic [COUNT_W-1:0]  glyphs_held = '0;
   logic [PERIOD_W-1:0] tick_count  = '0;
   logic [OFFS_W-1:0]   pixel_shift = '0;
   logic [SLOT_W-1:0]   lead_glyph  = '0;
   logic [ROW_W-1:0]    cur_row     = '0;
   logic [PERIOD_W-1:0] period_reg  = PERIOD_RESET;

   req_beat_type pending_beats [$];
   row_word_type expected_rows [$];
   int           beats_queued   = 0;
   int           beats_taken    = 0;
   int           rows_seen      = 0;
   int           fail_count     = 0;
   logic [7:0]   last_queued    = '0;

   initial begin
      foreach (glyph_mem[a]) glyph_mem[a] = '0;
   end

   // Glyphs past the store capacity read as blank.
   function automatic logic [BYTE_W-1:0] stored_byte(input int glyph, input int pos);
      if (glyph >= GLYPH_SLOTS) return '0;
      return glyph_mem[glyph * GLYPH_BYTES + pos];
   endfunction

   // Ten bytes of the current scan row from five glyphs, then a 0..15 bit shift.
   // Offsets of 8 and up skip a whole byte and shift the rest by the remainder.
   function automatic logic [PIX_W-1:0] shifted_row_pixels();
      logic [BYTE_W-1:0] lane [10];
      logic [15:0]       pair;
      logic [PIX_W-1:0]  pix;
      int                j;
      int                base;
      int                sh;
      pix = '0;
      for (j = 0; j < 5; j++) begin
         lane[2*j]   = stored_byte(int'(lead_glyph) + j, 2 * int'(cur_row));
         lane[2*j+1] = stored_byte(int'(lead_glyph) + j, 2 * int'(cur_row) + 1);
      end
      base = pixel_shift[3] ? 1 : 0;
      sh   = int'(pixel_shift[2:0]);
      for (j = 0; j < 8; j++) begin
         pair = {lane[j+base+1], lane[j+base]} >> sh;
         pix[8*j +: 8] = pair[7:0];
      end
      return pix;
   endfunction

   task automatic model_beat(input logic cmd, input logic [BYTE_W-1:0] b);
      row_word_type w;
      if (cmd == CMD_BYTE) begin
         if (last_byte == START_FIRST && b == START_SECOND) scrolling = 1'b1;
         // The stop pair clears everything it owns, but its second byte is still stored.
         if (last_byte == START_SECOND && b == START_FIRST) begin
            scrolling   = 1'b0;
            slot_ptr    = '0;
            byte_ptr    = '0;
            glyphs_held = '0;
            foreach (glyph_mem[a]) glyph_mem[a] = '0;
         end
         last_byte = b;
         if (slot_ptr < GLYPH_SLOTS) glyph_mem[int'(slot_ptr) * GLYPH_BYTES + int'(byte_ptr)] = b;
         byte_ptr = byte_ptr + 1'b1;
         if (byte_ptr == '0) begin
            if (slot_ptr < GLYPH_SLOTS) slot_ptr = slot_ptr + 1'b1;
            if (glyphs_held < GLYPH_SLOTS) glyphs_held = glyphs_held + 1'b1;
         end
      end else if (scrolling) begin
         tick_count = tick_count + 1'b1;
         if (tick_count >= period_reg) begin
            tick_count = '0;
            if (pixel_shift == 4'd15) begin
               pixel_shift = '0;
               // With no glyphs held the lead glyph falls back to zero.
               if ({1'b0, lead_glyph} + 6'd1 >= glyphs_held) lead_glyph = '0;
               else lead_glyph = lead_glyph + 1'b1;
            end else begin
               pixel_shift = pixel_shift + 1'b1;
            end
         end
         w.row    = cur_row;
         w.pixels = shifted_row_pixels();
         expected_rows.push_back(w);
         cur_row = cur_row + 1'b1;
      end
   endtask

   // ------------------------------------------------------------------
   // Stimulus builders. They only fill the pending queue; the driver paces it.
   // ------------------------------------------------------------------
   function automatic void queue_beat(input logic cmd, input logic [7:0] v);
      req_beat_type nb;
      nb.cmd   = cmd;
      nb.value = v;
      pending_beats.push_back(nb);
      beats_queued++;
      if (cmd == CMD_BYTE) last_queued = v;
   endfunction

   // Glyph content. A stray stop pair inside would wipe the fill, so it is steered away.
   function automatic void queue_bytes(input int n);
      logic [7:0] v;
      for (int k = 0; k < n; k++) begin
         v = 8'($urandom_range(0, 255));
         if (last_queued == START_SECOND && v == START_FIRST) v = ~v;
         queue_beat(CMD_BYTE, v);
      end
   endfunction

   function automatic void queue_ticks(input int n);
      for (int k = 0; k < n; k++) queue_beat(CMD_TICK, 8'($urandom_range(0, 255)));
   endfunction

   // A well-formed scene: optional clear, glyph bytes, start pair, then scan ticks.
   function automatic void queue_scene(input int fill, input int ticks, input bit clear);
      if (clear) begin
         queue_beat(CMD_BYTE, START_SECOND);
         queue_beat(CMD_BYTE, START_FIRST);
      end
      queue_bytes(fill);
      queue_beat(CMD_BYTE, START_FIRST);
      queue_beat(CMD_BYTE, START_SECOND);
      queue_ticks(ticks);
   endfunction

   // Broken pairs, lone marker bytes, raw bytes and ticks in random order.
   function automatic void queue_noise(input int n);
      noise_kind_type kind;
      for (int k = 0; k < n; k++) begin
         kind = noise_kind_type'($urandom_range(0, 5));
         case (kind)
            NOISE_TICK:        queue_ticks(1);
            NOISE_RAW_BYTE:    queue_beat(CMD_BYTE, 8'($urandom_range(0, 255)));
            NOISE_HALF_START: begin
               queue_beat(CMD_BYTE, START_FIRST);
               queue_beat(CMD_BYTE, 8'($urandom_range(0, 255)));
            end
            NOISE_HALF_STOP: begin
               queue_beat(CMD_BYTE, START_SECOND);
               queue_beat(CMD_BYTE, 8'($urandom_range(0, 255)));
            end
            NOISE_LONE_FIRST:  queue_beat(CMD_BYTE, START_FIRST);
            default:           queue_beat(CMD_BYTE, START_SECOND);
         endcase
      end
   endfunction

   // Waits until every queued beat is taken and every row has come back, then lets
   // the block finish whatever it may still be doing.
   task automatic settle_idle();
      while (beats_taken != beats_queued || expected_rows.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_period(input logic [PERIOD_W-1:0] v);
      settle_idle();
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= v;
      period_reg = v;
      @(posedge clock);
      csr_wen   <= 1'b0;
      csr_wdata <= 16'($urandom_range(0, 65535));
   endtask

   // ------------------------------------------------------------------
   // Test sequence.
   // ------------------------------------------------------------------
   initial begin
      logic [PERIOD_W-1:0] pick;
      int                  scenes;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the fastest scroll rate.
      write_period(16'd1);
      queue_beat(CMD_TICK, 8'hFF);                 // tick while stopped: ignored
      queue_beat(CMD_BYTE, 8'hFF);
      queue_beat(CMD_BYTE, 8'h00);
      queue_beat(CMD_BYTE, 8'h80);
      queue_beat(CMD_BYTE, 8'h01);
      queue_beat(CMD_BYTE, START_SECOND);          // stop pair clears the store
      queue_beat(CMD_BYTE, START_FIRST);
      queue_beat(CMD_BYTE, START_FIRST);           // start pair with no glyph held
      queue_beat(CMD_BYTE, START_SECOND);
      queue_ticks(17);                             // offset wraps while glyph count is zero

      // Slowest period: the offset never moves.
      write_period(16'hFFFF);
      queue_scene(64, 20, 1'b1);

      // Random scenes under a spread of periods. Moving from a long period to a short
      // one leaves the tick counter above the new period.
      while (beats_queued < RANDOM_TARGET) begin
         case ($urandom_range(0, 5))
            0:       pick = 16'd1;
            1:       pick = 16'd2;
            2:       pick = 16'd3;
            3:       pick = PERIOD_RESET;
            4:       pick = 16'($urandom_range(4, 12));
            default: pick = 16'($urandom_range(13, 65534));
         endcase
         write_period(pick);
         scenes = $urandom_range(1, 3);
         for (int s = 0; s < scenes; s++) begin
            if ($urandom_range(0, 9) < 7)
               queue_scene($urandom_range(0, 3) * GLYPH_BYTES + $urandom_range(0, 40),
                           $urandom_range(10, 50), $urandom_range(0, 3) != 0);
            else
               queue_noise($urandom_range(4, 16));
         end
      end

      // Deep run: overfill the store, then scroll until the lead glyph nears the end,
      // so the five-glyph window reads past the capacity.
      write_period(16'd1);
      queue_scene(DEEP_FILL_BYTES, DEEP_TICKS, 1'b1);
      // The lead glyph survives the clear and now points past what is held.
      queue_scene(GLYPH_BYTES, 30, 1'b1);

      settle_idle();
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // ------------------------------------------------------------------
   // Driver: bursts of random length with random gaps. A beat stays on the bus
   // until it is taken; the model advances on the edge that takes it.
   // ------------------------------------------------------------------
   int           burst_left = 0;
   int           gap_left   = 0;
   req_beat_type next_beat;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            model_beat(req_tuser[0], req_tdata);
            beats_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
               if (burst_left == 0) burst_left = $urandom_range(1, 24);
               next_beat = pending_beats.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= next_beat.cmd;
               req_tdata  <= next_beat.value;
               burst_left--;
               if (burst_left == 0)
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver ready: patterns that change at random intervals, plus two long
   // hold-offs so the output register fills and the block stalls its input.
   // ------------------------------------------------------------------
   ready_mode_type ready_mode = RDY_FREE;
   int             mode_left  = 0;
   int             hold_left  = 0;
   int             holds_done = 0;
   int             ready_cycle = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         ready_cycle++;
         if ((holds_done == 0 && rows_seen >= FIRST_HOLD_ROW) ||
             (holds_done == 1 && rows_seen >= SECOND_HOLD_ROW)) begin
            hold_left = LONG_HOLD_LEN;
            holds_done++;
         end
         if (mode_left == 0) begin
            ready_mode = ready_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(30, 200);
         end else begin
            mode_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (ready_mode)
               RDY_FREE:    rsp_tready <= 1'b1;
               RDY_COIN:    rsp_tready <= 1'($urandom_range(0, 1));
               RDY_SPARSE:  rsp_tready <= ($urandom_range(0, 3) == 0);
               default:     rsp_tready <= (ready_cycle % 3 == 0);
            endcase
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: every taken row word is checked against the oldest expected one.
   // ------------------------------------------------------------------
   row_word_type want_row;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rows_seen <= rows_seen + 1;
         if (expected_rows.size() == 0) begin
            $error("row word with nothing expected: row_index %0d, row_pixels %h",
                   rsp_tdata[3:0], rsp_tdata[67:4]);
            fail_count++;
         end else begin
            want_row = expected_rows.pop_front();
            if (rsp_tdata[3:0] !== want_row.row) begin
               $error("row_index: expected %0d, actual %0d", want_row.row, rsp_tdata[3:0]);
               fail_count++;
            end
            if (rsp_tdata[67:4] !== want_row.pixels) begin
               $error("row_pixels: expected %h, actual %h", want_row.pixels, rsp_tdata[67:4]);
               fail_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: too long without any beat taken on either side ends the run.
   // ------------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/slmr_pkg.sv
hdl/slmr_glyph_store.sv
hdl/slmr_row_shifter.sv
hdl/scrolling_led_matrix_row_composer.sv
verif/tb_scrolling_led_matrix_row_composer.sv
